// File: rtl/v3alu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helper for the 3D vector ALU.
package v3alu_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int WIDE_W    = PROD_W + 2;
	localparam int ROOT_W    = PROD_W / 2;
	localparam int IN_DATA_W  = 7 * DATA_W;
	localparam int OUT_DATA_W = 4 * DATA_W;

	typedef enum logic [2:0] {
		ACT_ADD   = 3'd0,
		ACT_SUB   = 3'd1,
		ACT_DOT   = 3'd2,
		ACT_CROSS = 3'd3,
		ACT_SCALE = 3'd4,
		ACT_EQ    = 3'd5,
		ACT_LEN   = 3'd6
	} act_t;

	typedef struct packed {
		logic signed [WIDE_W-1:0] val;
		logic                     eq;
	} lane_res_t;

	typedef struct packed {
		logic [DATA_W-1:0] rx;
		logic [DATA_W-1:0] ry;
		logic [DATA_W-1:0] rz;
		logic [DATA_W-1:0] sc;
		logic              eq;
		logic              ov;
		logic              is_len;
	} payload_t;

	typedef struct packed {
		logic [DATA_W-1:0] v;
		logic              ov;
	} sat_t;

	function automatic sat_t sat32(input logic signed [WIDE_W-1:0] x);
		sat_t r;
		if (x[WIDE_W-1:DATA_W-1] == {(WIDE_W-DATA_W+1){x[WIDE_W-1]}}) begin
			r.v  = x[DATA_W-1:0];
			r.ov = 1'b0;
		end else begin
			r.v  = x[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
			r.ov = 1'b1;
		end
		return r;
	endfunction

endpackage

// File: rtl/vector3_alu_top.sv
`timescale 1ns / 1ps
// Top level of the 3D vector ALU: lanes, merge, square root, output register.
//
// Channel | Dir | tdata (low bit up)                          | tuser (low bit up)
// s_*     | in  | a_x, a_y, a_z, b_x, b_y, b_z, factor (224b) | action (3b)
// m_*     | out | r_x, r_y, r_z, scalar_out (128b)            | equal_flag, overflow
//
// One transaction per cycle sustained while the output is not stalled; there are
// 36 register stages from input to output (two lane stages, one merge stage, 32
// square root stages, one output register). The 32-stage root pipeline sets depth.
// The whole pipe advances together whenever the output register is empty or
// being taken; a stall on m_tready holds every stage and drops s_tready.
// Reset clears the valid bits and lane act_s1 only; data registers are not reset.
module vector3_alu_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, factor
	input  logic [v3alu_pkg::IN_DATA_W-1:0]      s_tdata,
	// action
	input  logic [2:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// r_x, r_y, r_z, scalar_out
	output logic [v3alu_pkg::OUT_DATA_W-1:0]     m_tdata,
	// equal_flag, overflow
	output logic [1:0]                           m_tuser
);
	import v3alu_pkg::*;

	localparam int DEPTH = ROOT_W;

	logic en;
	act_t act_in, act_s1, act_s2;
	logic signed [DATA_W-1:0] ax, ay, az, bx, by, bz, f;
	lane_res_t rx_s2, ry_s2, rz_s2;
	payload_t pay_s3;
	logic [PROD_W-1:0] rad_s3;
	logic [ROOT_W-1:0] root;
	payload_t pay_q [1:DEPTH];
	logic     vld_q [0:DEPTH+2];
	logic     m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0] m_tuser_q;

	// unpack the input transaction
	assign act_in = act_t'(s_tuser);
	assign ax = s_tdata[0*DATA_W +: DATA_W];
	assign ay = s_tdata[1*DATA_W +: DATA_W];
	assign az = s_tdata[2*DATA_W +: DATA_W];
	assign bx = s_tdata[3*DATA_W +: DATA_W];
	assign by = s_tdata[4*DATA_W +: DATA_W];
	assign bz = s_tdata[5*DATA_W +: DATA_W];
	assign f  = s_tdata[6*DATA_W +: DATA_W];

	// advance the pipe when the output slot is free or draining
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	// cross operands: x = ay*bz - az*by, y = az*bx - ax*bz, z = ax*by - ay*bx
	v3alu_lane u_lane_x (
		.clk, .arst_n, .en, .act(act_in), .ai(ax), .bi(bx), .f,
		.cu_a(ay), .cu_b(bz), .cv_a(az), .cv_b(by), .res_s2(rx_s2)
	);
	v3alu_lane u_lane_y (
		.clk, .arst_n, .en, .act(act_in), .ai(ay), .bi(by), .f,
		.cu_a(az), .cu_b(bx), .cv_a(ax), .cv_b(bz), .res_s2(ry_s2)
	);
	v3alu_lane u_lane_z (
		.clk, .arst_n, .en, .act(act_in), .ai(az), .bi(bz), .f,
		.cu_a(ax), .cu_b(by), .cv_a(ay), .cv_b(bx), .res_s2(rz_s2)
	);

	// carry the action alongside the lane stages
	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= act_in;
			act_s2 <= act_s1;
		end
	end

	v3alu_merge u_merge (
		.clk, .en, .act(act_s2), .lx(rx_s2), .ly(ry_s2), .lz(rz_s2),
		.pay_s3, .rad_s3
	);

	v3alu_sqrt u_sqrt (
		.clk, .en, .rad(rad_s3), .root
	);

	// delay the merged payload to line up with the root
	always_ff @(posedge clk) begin
		if (en) begin
			pay_q[1] <= pay_s3;
			for (int i = 2; i <= DEPTH; i++) begin
				pay_q[i] <= pay_q[i-1];
			end
		end
	end

	// valid bits: two lane stages, merge, then root stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DEPTH + 2; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int i = 1; i <= DEPTH + 2; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// output register: fold in the length result and its saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= vld_q[DEPTH+2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q[0*DATA_W +: DATA_W] <= pay_q[DEPTH].rx;
			m_tdata_q[1*DATA_W +: DATA_W] <= pay_q[DEPTH].ry;
			m_tdata_q[2*DATA_W +: DATA_W] <= pay_q[DEPTH].rz;
			if (pay_q[DEPTH].is_len) begin
				m_tdata_q[3*DATA_W +: DATA_W] <= root[ROOT_W-1]
					? {1'b0, {(DATA_W-1){1'b1}}} : DATA_W'(root);
				m_tuser_q <= {root[ROOT_W-1], 1'b0};
			end else begin
				m_tdata_q[3*DATA_W +: DATA_W] <= pay_q[DEPTH].sc;
				m_tuser_q <= {pay_q[DEPTH].ov, pay_q[DEPTH].eq};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: rtl/v3alu_lane.sv
`timescale 1ns / 1ps
// One component lane: operand select, two multipliers, per-lane combine.
module v3alu_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  v3alu_pkg::act_t                       act,
	input  logic signed [v3alu_pkg::DATA_W-1:0]   ai,
	input  logic signed [v3alu_pkg::DATA_W-1:0]   bi,
	input  logic signed [v3alu_pkg::DATA_W-1:0]   f,
	input  logic signed [v3alu_pkg::DATA_W-1:0]   cu_a,
	input  logic signed [v3alu_pkg::DATA_W-1:0]   cu_b,
	input  logic signed [v3alu_pkg::DATA_W-1:0]   cv_a,
	input  logic signed [v3alu_pkg::DATA_W-1:0]   cv_b,
	output v3alu_pkg::lane_res_t                  res_s2
);
	import v3alu_pkg::*;

	logic signed [DATA_W-1:0] m0a, m0b;
	logic signed [PROD_W-1:0] p0_s1, p1_s1;
	logic signed [DATA_W:0]   sum_s1;
	logic                     eq_s1;
	act_t                     act_s1;

	// pick multiplier operands per action
	always_comb begin
		m0a = ai;
		m0b = bi;
		case (act)
			ACT_CROSS: begin
				m0a = cu_a;
				m0b = cu_b;
			end
			ACT_SCALE: m0b = f;
			ACT_LEN:   m0b = ai;
			default:   m0b = bi;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= ACT_ADD;
		end else if (en) begin
			act_s1 <= act;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1  <= m0a * m0b;
			p1_s1  <= cv_a * cv_b;
			sum_s1 <= (act == ACT_SUB) ? ({ai[DATA_W-1], ai} - {bi[DATA_W-1], bi})
			                           : ({ai[DATA_W-1], ai} + {bi[DATA_W-1], bi});
			eq_s1  <= (ai == bi);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.eq <= eq_s1;
			case (act_s1)
				ACT_ADD, ACT_SUB:
					res_s2.val <= WIDE_W'(sum_s1);
				ACT_DOT, ACT_SCALE, ACT_LEN:
					res_s2.val <= WIDE_W'(p0_s1);
				ACT_CROSS:
					res_s2.val <= WIDE_W'(p0_s1) - WIDE_W'(p1_s1);
				default:
					res_s2.val <= '0;
			endcase
		end
	end

endmodule

// File: rtl/v3alu_merge.sv
`timescale 1ns / 1ps
// Merge stage: combine lane results, rescale and saturate.
module v3alu_merge (
	input  logic                              clk,
	input  logic                              en,
	input  v3alu_pkg::act_t                   act,
	input  v3alu_pkg::lane_res_t              lx,
	input  v3alu_pkg::lane_res_t              ly,
	input  v3alu_pkg::lane_res_t              lz,
	output v3alu_pkg::payload_t               pay_s3,
	output logic [v3alu_pkg::PROD_W-1:0]      rad_s3
);
	import v3alu_pkg::*;

	logic signed [WIDE_W-1:0] dot_sum;
	sat_t     sx, sy, sz, sd;
	payload_t pay;
	logic [PROD_W-1:0] rad;

	assign dot_sum = lx.val + ly.val + lz.val;

	always_comb begin
		sx  = sat32(lx.val);
		sy  = sat32(ly.val);
		sz  = sat32(lz.val);
		sd  = sat32(dot_sum >>> FRAC_BITS);
		pay = '0;
		rad = '0;
		case (act)
			ACT_ADD, ACT_SUB: begin
				pay.rx = sx.v;
				pay.ry = sy.v;
				pay.rz = sz.v;
				pay.ov = sx.ov | sy.ov | sz.ov;
			end
			ACT_CROSS, ACT_SCALE: begin
				sx = sat32(lx.val >>> FRAC_BITS);
				sy = sat32(ly.val >>> FRAC_BITS);
				sz = sat32(lz.val >>> FRAC_BITS);
				pay.rx = sx.v;
				pay.ry = sy.v;
				pay.rz = sz.v;
				pay.ov = sx.ov | sy.ov | sz.ov;
			end
			ACT_DOT: begin
				pay.sc = sd.v;
				pay.ov = sd.ov;
			end
			ACT_EQ:  pay.eq = lx.eq & ly.eq & lz.eq;
			ACT_LEN: begin
				// sum of squares wraps modulo 2^64
				rad        = lx.val[PROD_W-1:0] + ly.val[PROD_W-1:0] + lz.val[PROD_W-1:0];
				pay.is_len = 1'b1;
			end
			default: pay = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s3 <= pay;
			rad_s3 <= rad;
		end
	end

endmodule

// File: rtl/v3alu_sqrt.sv
`timescale 1ns / 1ps
// Pipelined floor square root, one result bit per stage.
module v3alu_sqrt (
	input  logic                             clk,
	input  logic                             en,
	input  logic [v3alu_pkg::PROD_W-1:0]     rad,
	output logic [v3alu_pkg::ROOT_W-1:0]     root
);
	import v3alu_pkg::*;

	logic [PROD_W-1:0] rem_q [1:ROOT_W];
	logic [PROD_W-1:0] res_q [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam logic [PROD_W-1:0] BIT = PROD_W'(1) << (PROD_W - 2 - 2 * k);
		logic [PROD_W-1:0] rem_in, res_in, trial;
		if (k == 0) begin : g_first
			assign rem_in = rad;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k];
			assign res_in = res_q[k];
		end
		assign trial = res_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_q[k+1] <= rem_in - trial;
					res_q[k+1] <= (res_in >> 1) + BIT;
				end else begin
					rem_q[k+1] <= rem_in;
					res_q[k+1] <= res_in >> 1;
				end
			end
		end
	end

	assign root = res_q[ROOT_W][ROOT_W-1:0];

endmodule
